// ----- hdl/bsd_pkg.sv -----
// Package for the box signed distance block: field widths, payload structs
// and the record carried down the square-root cell chain. No dependencies.
`default_nettype none

package bsd_pkg;

	localparam int COORD_BITS = 16;
	localparam int DIST_BITS  = COORD_BITS + 1;
	localparam int ABS_BITS   = COORD_BITS + 1;   // |most negative| needs one more bit
	localparam int DIFF_BITS  = COORD_BITS + 2;   // signed |p|-|h|
	localparam int ROOT_BITS  = COORD_BITS;       // one result bit per cell
	localparam int RAD_BITS   = 2 * COORD_BITS;   // sum of three squares fits here
	localparam int REM_BITS   = ROOT_BITS + 1;
	localparam int SQRT_CELLS = ROOT_BITS;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] pos_x;
		logic signed [COORD_BITS-1:0] pos_y;
		logic signed [COORD_BITS-1:0] pos_z;
	} in_t;

	typedef struct packed {
		logic signed [DIST_BITS-1:0] distance;
		logic                        inside_res;
	} out_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] half_x;
		logic signed [COORD_BITS-1:0] half_y;
		logic signed [COORD_BITS-1:0] half_z;
	} half_t;

	// One square-root step's working set, plus the inside result riding along
	typedef struct packed {
		logic [RAD_BITS-1:0]  rad;
		logic [REM_BITS-1:0]  rem;
		logic [ROOT_BITS-1:0] root;
		logic                 in_box;
		logic [DIST_BITS-1:0] neg_dist;
	} cell_t;

	function automatic logic [ABS_BITS-1:0] abs_val(input logic signed [COORD_BITS-1:0] v);
		logic signed [ABS_BITS-1:0] w;
		w = ABS_BITS'(v);
		abs_val = w[ABS_BITS-1] ? ABS_BITS'(-w) : ABS_BITS'(w);
	endfunction

endpackage

`default_nettype wire

// ----- hdl/bsd_front.sv -----
// Front end: per-axis |p|-|h|, largest difference, squares of positive parts
// and their sum, three pipeline stages. Uses bsd_pkg.
`default_nettype none

module bsd_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  bsd_pkg::half_t      half,
	input  wire                 up_valid,
	output logic                up_ready,
	input  bsd_pkg::in_t        up_data,
	output logic                dn_valid,
	input  wire                 dn_ready,
	output bsd_pkg::cell_t      dn_data
);
	import bsd_pkg::*;

	logic                        valid_s1, valid_s2, valid_s3;
	logic                        adv_s1, adv_s2, adv_s3;
	logic signed [DIFF_BITS-1:0] d_s1 [3];
	logic [RAD_BITS-1:0]         sq_s2 [3];
	logic                        inside_s2;
	logic [DIST_BITS-1:0]        neg_s2;
	cell_t                       cell_s3;

	logic signed [DIFF_BITS-1:0] d_n [3];
	logic signed [DIFF_BITS-1:0] m01, dmax;
	logic [COORD_BITS-1:0]       pos_part [3];
	logic [RAD_BITS-1:0]         sum_n;

	// a stage takes new data when empty or when its contents move on
	assign adv_s3   = !valid_s3 || dn_ready;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign up_ready = adv_s1;

	always_comb begin
		d_n[0] = DIFF_BITS'(abs_val(up_data.pos_x)) - DIFF_BITS'(abs_val(half.half_x));
		d_n[1] = DIFF_BITS'(abs_val(up_data.pos_y)) - DIFF_BITS'(abs_val(half.half_y));
		d_n[2] = DIFF_BITS'(abs_val(up_data.pos_z)) - DIFF_BITS'(abs_val(half.half_z));
	end

	always_comb begin
		m01  = (d_s1[1] > d_s1[0]) ? d_s1[1] : d_s1[0];
		dmax = (d_s1[2] > m01) ? d_s1[2] : m01;
		for (int i = 0; i < 3; i++) begin
			// positive part is at most 2^(COORD_BITS-1), fits unsigned
			pos_part[i] = (d_s1[i] > 0) ? d_s1[i][COORD_BITS-1:0] : '0;
		end
	end

	assign sum_n = sq_s2[0] + sq_s2[1] + sq_s2[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= up_valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && up_valid) begin
			d_s1 <= d_n;
		end
		if (adv_s2 && valid_s1) begin
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= RAD_BITS'(pos_part[i]) * RAD_BITS'(pos_part[i]);
			end
			inside_s2 <= dmax[DIFF_BITS-1];
			neg_s2    <= dmax[DIST_BITS-1:0];
		end
		if (adv_s3 && valid_s2) begin
			cell_s3.rad      <= sum_n;
			cell_s3.rem      <= '0;
			cell_s3.root     <= '0;
			cell_s3.in_box   <= inside_s2;
			cell_s3.neg_dist <= neg_s2;
		end
	end

	assign dn_valid = valid_s3;
	assign dn_data  = cell_s3;

endmodule

`default_nettype wire

// ----- hdl/bsd_sqrt_cell.sv -----
// One cell of the digit-by-digit square root chain: takes two radicand bits,
// settles one root bit, registers the result. Uses bsd_pkg.
`default_nettype none

module bsd_sqrt_cell (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             up_valid,
	output logic            up_ready,
	input  bsd_pkg::cell_t  up_data,
	output logic            dn_valid,
	input  wire             dn_ready,
	output bsd_pkg::cell_t  dn_data
);
	import bsd_pkg::*;

	localparam int SH_BITS = REM_BITS + 2;

	logic              valid_q;
	cell_t             data_q;
	cell_t             next;
	logic [SH_BITS-1:0] sh, trial;

	assign up_ready = !valid_q || dn_ready;

	always_comb begin
		sh    = {up_data.rem, up_data.rad[RAD_BITS-1 -: 2]};
		trial = SH_BITS'({up_data.root, 2'b01});
		next  = up_data;
		next.rad = {up_data.rad[RAD_BITS-3:0], 2'b00};
		// remainder stays below 2*root+1, so REM_BITS always holds it
		if (sh >= trial) begin
			next.rem  = REM_BITS'(sh - trial);
			next.root = {up_data.root[ROOT_BITS-2:0], 1'b1};
		end else begin
			next.rem  = sh[REM_BITS-1:0];
			next.root = {up_data.root[ROOT_BITS-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= next;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule

`default_nettype wire

// ----- hdl/box_signed_distance.sv -----
// Box signed distance, top level: APB register file for the half extents,
// front end, square-root cell chain and output register.
// Depends on bsd_pkg, bsd_front, bsd_sqrt_cell.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one point (pos_x, pos_y,
//   pos_z, signed Q8.8). Output channel out_valid/out_stall/out_data carries
//   distance (signed Q9.8, negative inside) and inside_res. A transfer happens on a
//   rising edge with valid high and stall low.
//   The pipeline has 3 front stages (difference, square, sum), 16 root
//   cells (one result bit each) and the output register. One point per cycle
//   is taken and delivered while the output is not stalled.
//   Every stage moves on when it is empty or its successor moves, so bubbles
//   close up; with out_stall held, the chain fills and in_stall rises only
//   once all 20 stages hold a point.
//   Half extents are written over APB at 0x0, 0x4, 0x8 (low 16 bits of pwdata,
//   absolute value used); pready is always high and reads return the value.
//   Reset clears all valid flags and sets each half extent to 1.0 (0x0100).
`default_nettype none

module box_signed_distance (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_stall,
	input  bsd_pkg::in_t   in_data,
	output logic           out_valid,
	input  wire            out_stall,
	output bsd_pkg::out_t  out_data,
	input  wire            psel,
	input  wire            penable,
	input  wire            pwrite,
	input  wire [3:0]      paddr,
	input  wire [31:0]     pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);
	import bsd_pkg::*;

	localparam logic [1:0] REG_HALF_X = 2'd0;
	localparam logic [1:0] REG_HALF_Y = 2'd1;
	localparam logic [1:0] REG_HALF_Z = 2'd2;
	localparam logic [COORD_BITS-1:0] HALF_RESET = COORD_BITS'(256);

	half_t            half_q;
	logic [1:0]       reg_idx;
	logic             wr_en;

	logic             front_ready;
	logic             chain_valid [SQRT_CELLS+1];
	logic             chain_ready [SQRT_CELLS+1];
	cell_t            chain_data  [SQRT_CELLS+1];

	logic             out_valid_q;
	out_t             out_q;
	logic             last_ready;
	cell_t            last;

	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q.half_x <= HALF_RESET;
			half_q.half_y <= HALF_RESET;
			half_q.half_z <= HALF_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_HALF_X: half_q.half_x <= pwdata[COORD_BITS-1:0];
				REG_HALF_Y: half_q.half_y <= pwdata[COORD_BITS-1:0];
				REG_HALF_Z: half_q.half_z <= pwdata[COORD_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_HALF_X: prdata = 32'(unsigned'(half_q.half_x));
			REG_HALF_Y: prdata = 32'(unsigned'(half_q.half_y));
			REG_HALF_Z: prdata = 32'(unsigned'(half_q.half_z));
			default:    prdata = '0;
		endcase
	end

	bsd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.half     (half_q),
		.up_valid (in_valid),
		.up_ready (front_ready),
		.up_data  (in_data),
		.dn_valid (chain_valid[0]),
		.dn_ready (chain_ready[0]),
		.dn_data  (chain_data[0])
	);

	assign in_stall = !front_ready;

	for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_cell
		bsd_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (chain_valid[g]),
			.up_ready (chain_ready[g]),
			.up_data  (chain_data[g]),
			.dn_valid (chain_valid[g+1]),
			.dn_ready (chain_ready[g+1]),
			.dn_data  (chain_data[g+1])
		);
	end

	assign last       = chain_data[SQRT_CELLS];
	assign last_ready = !out_valid_q || !out_stall;
	assign chain_ready[SQRT_CELLS] = last_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (last_ready) begin
			out_valid_q <= chain_valid[SQRT_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (last_ready && chain_valid[SQRT_CELLS]) begin
			out_q.distance   <= last.in_box ? last.neg_dist : DIST_BITS'(last.root);
			out_q.inside_res <= last.in_box;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// ----- hdl/bsd_checker.sv -----
// Port-level checks for box_signed_distance, attached by the bind below.
// Uses bsd_pkg.
`default_nettype none

module bsd_checker (
	input wire            clk,
	input wire            arst_n,
	input wire            in_valid,
	input wire            in_stall,
	input bsd_pkg::in_t   in_data,
	input wire            out_valid,
	input wire            out_stall,
	input bsd_pkg::out_t  out_data
);
	import bsd_pkg::*;

	// a stalled input point stays offered and unchanged
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_data))
		else $error("input changed while stalled");

	// held result must not move
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");

	// inside results are strictly negative
	a_inside_neg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.inside_res |-> out_data.distance[DIST_BITS-1])
		else $error("inside result not negative");

	// outside or surface results are never negative
	a_outside_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.inside_res |-> !out_data.distance[DIST_BITS-1])
		else $error("outside result negative");

	// input back-pressure only once the chain is full behind a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

endmodule

bind box_signed_distance bsd_checker u_bsd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire
